/* sv/pcfb_pkg.sv */
// ----------------------------------------------------------------------------
// pcfb_pkg
// Shared types, constants and the crc helper of the pwm command frame builder.
// ----------------------------------------------------------------------------
package pcfb_pkg;

  // channel value slots carried on the command channel
  localparam int unsigned MaxChannels         = 8;
  localparam int unsigned ChannelCountDefault = 8;
  localparam int unsigned ValueW              = 16;
  localparam int unsigned SeqW                = 16;
  localparam int unsigned TsW                 = 32;
  localparam int unsigned ByteW               = 8;
  localparam int unsigned CfgIdxW             = 3;
  localparam int unsigned CfgDataW            = 16;
  localparam int unsigned QueueDepth          = 2;

  // frame layout
  localparam int unsigned HdrBytes      = 12;
  localparam int unsigned CrcBytes      = 2;
  localparam int unsigned FrameBytesMax = HdrBytes + 2 * MaxChannels + CrcBytes;
  localparam int unsigned FrameIdxW     = $clog2(FrameBytesMax);

  // crc-16-ccitt-false
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // command codes
  localparam logic CmdPwm       = 1'b0;
  localparam logic CmdHeartbeat = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStartWord    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVersion      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPwmCode      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeartbeatCode = 3'd3;
  localparam logic [CfgIdxW-1:0] RegValueLimit   = 3'd4;

  // register reset values
  localparam logic [15:0] StartWordReset     = 16'hAA55;
  localparam logic [7:0]  VersionReset       = 8'd1;
  localparam logic [7:0]  PwmCodeReset       = 8'd1;
  localparam logic [7:0]  HeartbeatCodeReset = 8'd16;
  localparam logic [15:0] ValueLimitReset    = 16'd10000;

  typedef struct packed {
    logic [15:0] start_word;
    logic [7:0]  protocol_version;
    logic [7:0]  pwm_message_code;
    logic [7:0]  heartbeat_message_code;
    logic [15:0] value_limit;
  } cfg_t;

  // one classified command, ready for the serializer
  typedef struct packed {
    logic                                heartbeat;
    logic [SeqW-1:0]                     seq;
    logic [TsW-1:0]                      ts;
    logic [MaxChannels-1:0][ValueW-1:0]  values;
  } desc_t;

  // one byte through the crc register, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/pcfb_cmd_if.sv */
// ----------------------------------------------------------------------------
// pcfb_cmd_if
// Command channel: pwm update or heartbeat with its timestamp.
// ----------------------------------------------------------------------------
interface pcfb_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] channel_value_0;
  logic [15:0] channel_value_1;
  logic [15:0] channel_value_2;
  logic [15:0] channel_value_3;
  logic [15:0] channel_value_4;
  logic [15:0] channel_value_5;
  logic [15:0] channel_value_6;
  logic [15:0] channel_value_7;
  logic [31:0] timestamp_ms;

  modport source (
    output valid, command, channel_value_0, channel_value_1, channel_value_2,
           channel_value_3, channel_value_4, channel_value_5, channel_value_6,
           channel_value_7, timestamp_ms,
    input  ready
  );
  modport sink (
    input  valid, command, channel_value_0, channel_value_1, channel_value_2,
           channel_value_3, channel_value_4, channel_value_5, channel_value_6,
           channel_value_7, timestamp_ms,
    output ready
  );
endinterface

/* sv/pcfb_cfg_if.sv */
// ----------------------------------------------------------------------------
// pcfb_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface pcfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/pcfb_byte_if.sv */
// ----------------------------------------------------------------------------
// pcfb_byte_if
// Frame byte stream with end-of-frame marker.
// ----------------------------------------------------------------------------
interface pcfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

/* sv/pcfb_regs.sv */
// ----------------------------------------------------------------------------
// pcfb_regs
// Configuration registers, written through the register write channel.
// ----------------------------------------------------------------------------
module pcfb_regs import pcfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pcfb_cfg_if.sink cfg_i,
  output cfg_t cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegStartWord:     cfg_d.start_word             = cfg_i.data;
        RegVersion:       cfg_d.protocol_version       = cfg_i.data[7:0];
        RegPwmCode:       cfg_d.pwm_message_code       = cfg_i.data[7:0];
        RegHeartbeatCode: cfg_d.heartbeat_message_code = cfg_i.data[7:0];
        RegValueLimit:    cfg_d.value_limit            = cfg_i.data;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_word             <= StartWordReset;
      cfg_q.protocol_version       <= VersionReset;
      cfg_q.pwm_message_code       <= PwmCodeReset;
      cfg_q.heartbeat_message_code <= HeartbeatCodeReset;
      cfg_q.value_limit            <= ValueLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* sv/pcfb_front.sv */
// ----------------------------------------------------------------------------
// pcfb_front
// Accepts commands, clamps channel values and stamps the sequence number.
// ----------------------------------------------------------------------------
module pcfb_front import pcfb_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = ChannelCountDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pcfb_cmd_if.sink cmd_i,
  input  cfg_t  cfg_i,
  output logic  push_valid_o,
  input  logic  push_ready_i,
  output desc_t push_desc_o
);

  logic              valid_q, valid_d;
  logic [SeqW-1:0]   seq_q, seq_d;
  desc_t             desc_q, desc_d;
  logic              accept;
  logic [ValueW-1:0] raw [MaxChannels];

  assign cmd_i.ready  = !valid_q || push_ready_i;
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign push_valid_o = valid_q;
  assign push_desc_o  = desc_q;

  assign raw[0] = cmd_i.channel_value_0;
  assign raw[1] = cmd_i.channel_value_1;
  assign raw[2] = cmd_i.channel_value_2;
  assign raw[3] = cmd_i.channel_value_3;
  assign raw[4] = cmd_i.channel_value_4;
  assign raw[5] = cmd_i.channel_value_5;
  assign raw[6] = cmd_i.channel_value_6;
  assign raw[7] = cmd_i.channel_value_7;

  // classify and clamp, sequence number advances before use
  always_comb begin
    seq_d   = seq_q;
    desc_d  = desc_q;
    valid_d = valid_q;
    if (push_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      seq_d            = seq_q + 1'b1;
      valid_d          = 1'b1;
      desc_d.heartbeat = (cmd_i.command == CmdHeartbeat);
      desc_d.seq       = seq_q + 1'b1;
      desc_d.ts        = cmd_i.timestamp_ms;
      for (int i = 0; i < MaxChannels; i++) begin
        if (i >= CHANNEL_COUNT) begin
          desc_d.values[i] = '0;
        end else if (raw[i] > cfg_i.value_limit) begin
          desc_d.values[i] = cfg_i.value_limit;
        end else begin
          desc_d.values[i] = raw[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seq_q   <= '0;
    end else begin
      valid_q <= valid_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

endmodule

/* sv/pcfb_queue.sv */
// ----------------------------------------------------------------------------
// pcfb_queue
// Small first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module pcfb_queue import pcfb_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  desc_t push_desc_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output desc_t pop_desc_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  desc_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

endmodule

/* sv/pcfb_back.sv */
// ----------------------------------------------------------------------------
// pcfb_back
// Serializer: walks one frame a byte per unstalled cycle, appends the crc.
// ----------------------------------------------------------------------------
module pcfb_back import pcfb_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = ChannelCountDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  pop_valid_i,
  output logic  pop_ready_o,
  input  desc_t pop_desc_i,
  pcfb_byte_if.source frame_o
);

  localparam int unsigned ChIdxW = $clog2(MaxChannels);
  localparam logic [FrameIdxW-1:0] HbLen  = FrameIdxW'(HdrBytes + CrcBytes);
  localparam logic [FrameIdxW-1:0] PwmLen = FrameIdxW'(HdrBytes + 2 * CHANNEL_COUNT + CrcBytes);
  localparam logic [15:0]          PwmPayloadLen = 16'(2 * CHANNEL_COUNT);

  logic                 busy_q, busy_d;
  desc_t                desc_q, desc_d;
  logic [FrameIdxW-1:0] idx_q, idx_d;
  logic [15:0]          crc_q, crc_d;
  logic                 ovalid_q, ovalid_d;
  logic [ByteW-1:0]     obyte_q, obyte_d;
  logic                 olast_q, olast_d;

  logic                 step, at_end;
  logic [FrameIdxW-1:0] len, slot;
  logic [ChIdxW-1:0]    ch;
  logic [15:0]          plen, val;
  logic [ByteW-1:0]     cur_byte;
  logic                 covered;

  assign frame_o.valid      = ovalid_q;
  assign frame_o.frame_byte = obyte_q;
  assign frame_o.frame_last = olast_q;

  assign len    = desc_q.heartbeat ? HbLen : PwmLen;
  assign plen   = desc_q.heartbeat ? 16'd0 : PwmPayloadLen;
  assign step   = busy_q && (!ovalid_q || frame_o.ready);
  assign at_end = (idx_q == len - 1'b1);
  assign pop_ready_o = !busy_q || (step && at_end);

  assign slot = idx_q - FrameIdxW'(HdrBytes);
  assign ch   = slot[1 +: ChIdxW];
  assign val  = desc_q.values[ch];

  // byte at the current frame position
  always_comb begin
    cur_byte = '0;
    covered  = 1'b1;
    if (idx_q >= len - FrameIdxW'(CrcBytes)) begin
      covered  = 1'b0;
      cur_byte = at_end ? crc_q[7:0] : crc_q[15:8];
    end else if (idx_q >= FrameIdxW'(HdrBytes)) begin
      cur_byte = slot[0] ? val[7:0] : val[15:8];
    end else begin
      case (idx_q)
        FrameIdxW'(0): begin
          cur_byte = cfg_i.start_word[15:8];
          covered  = 1'b0;
        end
        FrameIdxW'(1): begin
          cur_byte = cfg_i.start_word[7:0];
          covered  = 1'b0;
        end
        FrameIdxW'(2):  cur_byte = cfg_i.protocol_version;
        FrameIdxW'(3):  cur_byte = desc_q.heartbeat ? cfg_i.heartbeat_message_code
                                                    : cfg_i.pwm_message_code;
        FrameIdxW'(4):  cur_byte = desc_q.seq[15:8];
        FrameIdxW'(5):  cur_byte = desc_q.seq[7:0];
        FrameIdxW'(6):  cur_byte = desc_q.ts[31:24];
        FrameIdxW'(7):  cur_byte = desc_q.ts[23:16];
        FrameIdxW'(8):  cur_byte = desc_q.ts[15:8];
        FrameIdxW'(9):  cur_byte = desc_q.ts[7:0];
        FrameIdxW'(10): cur_byte = plen[15:8];
        FrameIdxW'(11): cur_byte = plen[7:0];
        default:        cur_byte = '0;
      endcase
    end
  end

  // frame walk, crc update and output register
  always_comb begin
    busy_d   = busy_q;
    desc_d   = desc_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (frame_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (step) begin
      ovalid_d = 1'b1;
      obyte_d  = cur_byte;
      olast_d  = at_end;
      idx_d    = idx_q + 1'b1;
      if (covered) begin
        crc_d = crc_feed(crc_q, cur_byte);
      end
      if (at_end) begin
        busy_d = 1'b0;
      end
    end
    if (pop_ready_o && pop_valid_i) begin
      busy_d = 1'b1;
      desc_d = pop_desc_i;
      idx_d  = '0;
      crc_d  = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q  <= desc_d;
    crc_q   <= crc_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule

/* sv/pwm_command_frame_builder_core.sv */
// ----------------------------------------------------------------------------
// pwm_command_frame_builder_core
// Turns pwm update and heartbeat commands into crc-protected byte frames.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i   - one item per command: pwm update (eight channel values) or
//             heartbeat, each with a millisecond timestamp.
//   cfg_i   - register writes (start word, version, message codes, value
//             limit); always ready, write only while no frame is in flight.
//   frame_o - frame bytes in wire order, frame_last marks the crc low byte.
// The first byte of a frame passes the front register, the command queue,
// the serializer descriptor register and the output byte register to frame_o.
// Throughput: one byte per cycle from the single serializer lane, while the
// receiver is ready; a pwm frame has 14 + 2*CHANNEL_COUNT bytes, heartbeat 14.
// A front register and a two-entry command queue keep cmd_i taking items
// while a frame is being sent; frames follow each other with no gap.
// Reset clears the sequence number, loads register defaults and empties the
// queue. When the receiver stalls, the output byte holds and the serializer
// waits; once the queue and the front register are full, cmd_i drops ready.
module pwm_command_frame_builder_core import pcfb_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = ChannelCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcfb_cmd_if.sink    cmd_i,
  pcfb_cfg_if.sink    cfg_i,
  pcfb_byte_if.source frame_o
);

  cfg_t  cfg;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  desc_t push_desc, pop_desc;

  // configuration registers
  pcfb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // command intake
  pcfb_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .cfg_i        (cfg),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  // decoupling queue
  pcfb_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  // frame serializer
  pcfb_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_desc_i  (pop_desc),
    .frame_o     (frame_o)
  );

endmodule
